### src/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared types, codes and constants of the stepper ramp step generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

    localparam int DEF_STEP_BITS = 24;
    localparam int DEF_FRAC_BITS = 16;

    localparam int ACT_W   = 2;
    localparam int COUNT_W = 25;
    localparam int TOP_W   = 16;
    localparam int PER_W   = 16;
    localparam int CMPV_W  = 15;
    localparam int RUN_W   = 2;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int MINS_W  = 16;
    localparam int SCALE_W = 32;
    localparam int THR_W   = 24;
    localparam int SLOPE_W = 32;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

    localparam logic [RUN_W-1:0] RUN_OFF  = 2'd0;
    localparam logic [RUN_W-1:0] RUN_ON   = 2'd1;
    localparam logic [RUN_W-1:0] RUN_HALT = 2'd2;

    localparam logic [IDX_W-1:0] CFG_MIN_SPEED  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LOAD_SCALE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RAMP_THR   = 2'd2;

    localparam logic [MINS_W-1:0]  RST_MIN_SPEED  = 16'd10;
    localparam logic [SCALE_W-1:0] RST_LOAD_SCALE = 32'd4000000;
    localparam logic [THR_W-1:0]   RST_RAMP_THR   = 24'd600;

    localparam logic [PER_W-1:0] PERIOD_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_SLOPE_GO,
        S_SLOPE_WAIT,
        S_PER_GO,
        S_PER_WAIT,
        S_EMIT
    } t_seq_state;

    typedef struct packed {
        logic       in_valid;
        logic       is_tick;
        logic       no_steps;
        logic       need_slope;
        logic       speed_zero;
        logic       div_done;
        logic       out_free;
    } t_seq_status;

    typedef struct packed {
        logic       in_ready;
        logic       ramp;
        logic       slope_start;
        logic       slope_load;
        logic       per_start;
        logic       per_zero;
        logic       per_load;
        logic       emit;
    } t_seq_ctrl;

endpackage

### src/srsg_in_if.sv
// ----------------------------------------------------------------------------
// srsg_in_if
// Input item channel: action, signed step count and top speed.
// ----------------------------------------------------------------------------
interface srsg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [srsg_pkg::ACT_W-1:0]           action;
    logic signed [srsg_pkg::COUNT_W-1:0]  step_count;
    logic [srsg_pkg::TOP_W-1:0]           top_speed;

    modport source (output valid, output action, output step_count, output top_speed,
                    input ready);
    modport sink (input valid, input action, input step_count, input top_speed,
                  output ready);
endinterface

### src/srsg_out_if.sv
// ----------------------------------------------------------------------------
// srsg_out_if
// Result channel: PWM period and compare, enables, direction and status.
// ----------------------------------------------------------------------------
interface srsg_out_if #(
    parameter int STEP_BITS = srsg_pkg::DEF_STEP_BITS
);
    logic                          valid;
    logic                          ready;
    logic [srsg_pkg::PER_W-1:0]    period_load;
    logic [srsg_pkg::CMPV_W-1:0]   pulse_compare;
    logic                          pulse_enable;
    logic                          driver_enable_n;
    logic                          direction;
    logic [srsg_pkg::RUN_W-1:0]    run_status;
    logic [STEP_BITS-1:0]          steps_left;

    modport source (output valid, output period_load, output pulse_compare,
                    output pulse_enable, output driver_enable_n, output direction,
                    output run_status, output steps_left, input ready);
    modport sink (input valid, input period_load, input pulse_compare,
                  input pulse_enable, input driver_enable_n, input direction,
                  input run_status, input steps_left, output ready);
endinterface

### src/stepper_ramp_step_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_core
// Trapezoidal ramp step generator for one stepper motor.
// ----------------------------------------------------------------------------
// Items arrive on i_item with a valid/ready handshake: a move command loads the
// signed step count and top speed, a stop turns the motor off, and a tick marks
// the end of one PWM period. Every accepted beat yields exactly one beat on
// o_result with the PWM period and compare value, the enables, the direction,
// the run status and the steps left.
// Move, stop and unused actions go from acceptance straight to the emit state.
// A tick runs the ramp update, then the deceleration slope division when the
// speed rises with a nonzero deceleration divisor, then the period division
// unless the speed is zero; both divisions share the single radix-2 divider.
// The block takes one item at a time and holds i_item.ready low until the
// result is loaded into the output register, so no new item is accepted
// before the result of the last one is in that register.
// A stalled receiver holds the result in the output register; the next item
// is accepted but its result waits until that beat has been taken.
// Reset clears the profile, sets the registers to their defaults and leaves
// the motor off with the driver disabled. Configuration writes on the i_cfg
// port take effect at once and are meant for times when the block is idle.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator_core #(
    parameter int STEP_BITS = srsg_pkg::DEF_STEP_BITS,
    parameter int FRAC_BITS = srsg_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srsg_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [srsg_pkg::CFG_W-1:0]   i_cfg_data,
    srsg_in_if.sink                      i_item,
    srsg_out_if.source                   o_result
);

    localparam int SPD_W  = srsg_pkg::MINS_W + FRAC_BITS;
    localparam int DVD_W  = srsg_pkg::SCALE_W + FRAC_BITS;
    localparam int BUD_W  = STEP_BITS - 1;
    localparam int DSR_W  = (SPD_W > BUD_W) ? SPD_W : BUD_W;
    localparam int CW     = ((SPD_W > srsg_pkg::SLOPE_W) ? SPD_W : srsg_pkg::SLOPE_W) + 1;
    localparam int TW     = (STEP_BITS > srsg_pkg::THR_W) ? STEP_BITS : srsg_pkg::THR_W;
    localparam int MW     = (STEP_BITS > srsg_pkg::COUNT_W) ? STEP_BITS : srsg_pkg::COUNT_W;
    localparam logic [SPD_W-1:0] ACC_INC = SPD_W'(1) << (FRAC_BITS - 5);

    logic [srsg_pkg::MINS_W-1:0]  r_min_speed, n_min_speed;
    logic [srsg_pkg::SCALE_W-1:0] r_load_scale, n_load_scale;
    logic [srsg_pkg::THR_W-1:0]   r_ramp_thr, n_ramp_thr;

    logic [STEP_BITS-1:0]         r_remaining, n_remaining;
    logic [BUD_W-1:0]             r_budget, n_budget;
    logic [BUD_W-1:0]             r_ddiv, n_ddiv;
    logic [SPD_W-1:0]             r_speed, n_speed;
    logic [srsg_pkg::SLOPE_W-1:0] r_slope, n_slope;
    logic [srsg_pkg::MINS_W-1:0]  r_limit, n_limit;
    logic [srsg_pkg::RUN_W-1:0]   r_run, n_run;
    logic                         r_dir, n_dir;
    logic                         r_drv_off, n_drv_off;
    logic [srsg_pkg::PER_W-1:0]   r_period, n_period;

    logic                         r_out_valid, n_out_valid;
    logic [srsg_pkg::PER_W-1:0]   r_o_period;
    logic                         r_o_pen;
    logic                         r_o_drv_n;
    logic                         r_o_dir;
    logic [srsg_pkg::RUN_W-1:0]   r_o_run;
    logic [STEP_BITS-1:0]         r_o_steps;

    srsg_pkg::t_seq_status        seq_status;
    srsg_pkg::t_seq_ctrl          seq_ctrl;

    logic                         accept;
    logic [SPD_W-1:0]             min_q;
    logic [SPD_W-1:0]             lim_q;
    logic                         accel;
    logic [SPD_W:0]               speed_inc;
    logic [CW-1:0]                floor_sum;
    logic [CW-1:0]                speed_c;
    logic [srsg_pkg::COUNT_W-1:0] mag;
    logic [MW-1:0]                mag_w;

    logic                         div_start;
    logic [DVD_W-1:0]             div_dividend;
    logic [DSR_W-1:0]             div_divisor;
    logic                         div_done;
    logic [DVD_W-1:0]             div_quotient;

    srsg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (seq_status),
        .o_ctrl   (seq_ctrl)
    );

    srsg_div #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign accept    = i_item.valid && seq_ctrl.in_ready;
    assign min_q     = {r_min_speed, {FRAC_BITS{1'b0}}};
    assign lim_q     = {r_limit, {FRAC_BITS{1'b0}}};
    assign accel     = (r_budget != '0) && (TW'(r_remaining) > TW'(r_ramp_thr));
    assign speed_inc = {1'b0, r_speed} + {1'b0, ACC_INC};
    assign floor_sum = CW'(min_q) + CW'(r_slope);
    assign speed_c   = CW'(r_speed);
    assign mag       = i_item.step_count[srsg_pkg::COUNT_W-1]
                       ? (srsg_pkg::COUNT_W'(0) - i_item.step_count)
                       : i_item.step_count;
    assign mag_w     = MW'(mag);

    assign seq_status.in_valid   = i_item.valid;
    assign seq_status.is_tick    = (i_item.action == srsg_pkg::ACT_TICK);
    assign seq_status.no_steps   = (r_remaining == '0);
    assign seq_status.need_slope = accel && (r_ddiv != '0);
    assign seq_status.speed_zero = (r_speed == '0);
    assign seq_status.div_done   = div_done;
    assign seq_status.out_free   = !r_out_valid || o_result.ready;

    assign div_start    = seq_ctrl.slope_start || seq_ctrl.per_start;
    assign div_dividend = seq_ctrl.slope_start ? DVD_W'(r_speed)
                                               : {r_load_scale, {FRAC_BITS{1'b0}}};
    assign div_divisor  = seq_ctrl.slope_start ? DSR_W'(r_ddiv) : DSR_W'(r_speed);

    always_comb begin
        n_min_speed  = r_min_speed;
        n_load_scale = r_load_scale;
        n_ramp_thr   = r_ramp_thr;
        n_remaining  = r_remaining;
        n_budget     = r_budget;
        n_ddiv       = r_ddiv;
        n_speed      = r_speed;
        n_slope      = r_slope;
        n_limit      = r_limit;
        n_run        = r_run;
        n_dir        = r_dir;
        n_drv_off    = r_drv_off;
        n_period     = r_period;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srsg_pkg::CFG_MIN_SPEED:  n_min_speed  = i_cfg_data[srsg_pkg::MINS_W-1:0];
                srsg_pkg::CFG_LOAD_SCALE: n_load_scale = i_cfg_data[srsg_pkg::SCALE_W-1:0];
                srsg_pkg::CFG_RAMP_THR:   n_ramp_thr   = i_cfg_data[srsg_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end

        if (accept) begin
            n_period = '0;
            unique case (i_item.action)
                srsg_pkg::ACT_MOVE: begin
                    n_dir = i_item.step_count[srsg_pkg::COUNT_W-1];
                    if (mag_w > MW'({STEP_BITS{1'b1}})) begin
                        n_remaining = {STEP_BITS{1'b1}};
                    end else begin
                        n_remaining = STEP_BITS'(mag_w);
                    end
                    n_limit = (i_item.top_speed < r_min_speed) ? r_min_speed
                                                               : i_item.top_speed;
                end
                srsg_pkg::ACT_STOP: begin
                    n_run     = srsg_pkg::RUN_OFF;
                    n_drv_off = 1'b1;
                end
                srsg_pkg::ACT_TICK: begin
                    if (r_run != srsg_pkg::RUN_ON) begin
                        n_budget = r_remaining[STEP_BITS-1:1];
                        n_ddiv   = r_remaining[STEP_BITS-1:1];
                        n_speed  = min_q;
                    end
                end
                default: begin
                end
            endcase
        end

        if (seq_ctrl.ramp) begin
            if (r_remaining != '0) begin
                if (accel) begin
                    if (speed_inc > {1'b0, lim_q}) begin
                        n_speed = lim_q;
                    end else begin
                        n_speed = speed_inc[SPD_W-1:0];
                    end
                    n_budget = r_budget - BUD_W'(1);
                    if (r_ddiv == '0) begin
                        n_slope = '1;
                    end
                end else if (r_ddiv != '0) begin
                    if (speed_c < floor_sum) begin
                        n_speed = min_q;
                    end else begin
                        n_speed = SPD_W'(speed_c - CW'(r_slope));
                    end
                end
                n_run       = srsg_pkg::RUN_ON;
                n_drv_off   = 1'b0;
                n_remaining = r_remaining - STEP_BITS'(1);
            end else begin
                n_run = srsg_pkg::RUN_HALT;
            end
        end

        if (seq_ctrl.slope_load) begin
            n_slope = div_quotient[srsg_pkg::SLOPE_W-1:0];
        end

        if (seq_ctrl.per_zero) begin
            n_period = srsg_pkg::PERIOD_SAT;
        end else if (seq_ctrl.per_load) begin
            if (div_quotient[DVD_W-1:srsg_pkg::PER_W] != '0) begin
                n_period = srsg_pkg::PERIOD_SAT;
            end else begin
                n_period = div_quotient[srsg_pkg::PER_W-1:0];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (seq_ctrl.emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed  <= srsg_pkg::RST_MIN_SPEED;
            r_load_scale <= srsg_pkg::RST_LOAD_SCALE;
            r_ramp_thr   <= srsg_pkg::RST_RAMP_THR;
            r_remaining  <= '0;
            r_budget     <= '0;
            r_ddiv       <= '0;
            r_speed      <= {srsg_pkg::RST_MIN_SPEED, {FRAC_BITS{1'b0}}};
            r_slope      <= '0;
            r_limit      <= '0;
            r_run        <= srsg_pkg::RUN_OFF;
            r_dir        <= 1'b0;
            r_drv_off    <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_min_speed  <= n_min_speed;
            r_load_scale <= n_load_scale;
            r_ramp_thr   <= n_ramp_thr;
            r_remaining  <= n_remaining;
            r_budget     <= n_budget;
            r_ddiv       <= n_ddiv;
            r_speed      <= n_speed;
            r_slope      <= n_slope;
            r_limit      <= n_limit;
            r_run        <= n_run;
            r_dir        <= n_dir;
            r_drv_off    <= n_drv_off;
            r_out_valid  <= n_out_valid;
        end
        r_period <= n_period;
        if (seq_ctrl.emit) begin
            r_o_period <= r_period;
            r_o_pen    <= (r_run == srsg_pkg::RUN_ON);
            r_o_drv_n  <= r_drv_off;
            r_o_dir    <= r_dir;
            r_o_run    <= r_run;
            r_o_steps  <= r_remaining;
        end
    end

    assign i_item.ready             = seq_ctrl.in_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.period_load     = r_o_period;
    assign o_result.pulse_compare   = r_o_period[srsg_pkg::PER_W-1:1];
    assign o_result.pulse_enable    = r_o_pen;
    assign o_result.driver_enable_n = r_o_drv_n;
    assign o_result.direction       = r_o_dir;
    assign o_result.run_status      = r_o_run;
    assign o_result.steps_left      = r_o_steps;

endmodule

### src/srsg_div.sv
// ----------------------------------------------------------------------------
// srsg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srsg_div #(
    parameter int DVD_W = 48,
    parameter int DSR_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DSR_W-1:0] r_dsr, n_dsr;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dsr};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!diff[DSR_W+1]) begin
                n_rem = diff[DSR_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DSR_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/srsg_seq.sv
// ----------------------------------------------------------------------------
// srsg_seq
// Sequencer that steps one item through ramp update, slope and period division.
// ----------------------------------------------------------------------------
module srsg_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srsg_pkg::t_seq_status i_status,
    output srsg_pkg::t_seq_ctrl   o_ctrl
);

    srsg_pkg::t_seq_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srsg_pkg::S_IDLE: begin
                if (i_status.in_valid) begin
                    n_state = i_status.is_tick ? srsg_pkg::S_RAMP : srsg_pkg::S_EMIT;
                end
            end
            srsg_pkg::S_RAMP: begin
                if (!i_status.no_steps && i_status.need_slope) begin
                    n_state = srsg_pkg::S_SLOPE_GO;
                end else begin
                    n_state = srsg_pkg::S_PER_GO;
                end
            end
            srsg_pkg::S_SLOPE_GO: n_state = srsg_pkg::S_SLOPE_WAIT;
            srsg_pkg::S_SLOPE_WAIT: begin
                if (i_status.div_done) begin
                    n_state = srsg_pkg::S_PER_GO;
                end
            end
            srsg_pkg::S_PER_GO: begin
                n_state = i_status.speed_zero ? srsg_pkg::S_EMIT : srsg_pkg::S_PER_WAIT;
            end
            srsg_pkg::S_PER_WAIT: begin
                if (i_status.div_done) begin
                    n_state = srsg_pkg::S_EMIT;
                end
            end
            srsg_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = srsg_pkg::S_IDLE;
                end
            end
            default: n_state = srsg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            srsg_pkg::S_IDLE:       o_ctrl.in_ready = 1'b1;
            srsg_pkg::S_RAMP:       o_ctrl.ramp = 1'b1;
            srsg_pkg::S_SLOPE_GO:   o_ctrl.slope_start = 1'b1;
            srsg_pkg::S_SLOPE_WAIT: o_ctrl.slope_load = i_status.div_done;
            srsg_pkg::S_PER_GO: begin
                o_ctrl.per_start = !i_status.speed_zero;
                o_ctrl.per_zero  = i_status.speed_zero;
            end
            srsg_pkg::S_PER_WAIT:   o_ctrl.per_load = i_status.div_done;
            srsg_pkg::S_EMIT:       o_ctrl.emit = i_status.out_free;
            default:                o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
